@@ rtl/core/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon test core.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int NUM_VERTICES = 10;
  localparam int IDX_W        = $clog2(NUM_VERTICES);
  localparam int VIDX_W       = 4;
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VERTICES - 1);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  typedef struct packed {
    logic en;
    logic phase;
  } edge_ctl_t;

endpackage

@@ rtl/core/pip_vstore.sv @@
// ----------------------------------------------------------------------------
// pip_vstore
// Polygon vertex register file, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pip_vstore
  import pip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic signed [COORD_W-1:0] wr_x,
  input  logic signed [COORD_W-1:0] wr_y,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic signed [COORD_W-1:0] rd_x,
  output logic signed [COORD_W-1:0] rd_y
);

  logic signed [COORD_W-1:0] vx_r [NUM_VERTICES];
  logic signed [COORD_W-1:0] vy_r [NUM_VERTICES];
  logic signed [COORD_W-1:0] rd_x_r;
  logic signed [COORD_W-1:0] rd_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
    end else if (wr_en) begin
      vx_r[wr_addr] <= wr_x;
      vy_r[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x_r <= vx_r[rd_addr];
    rd_y_r <= vy_r[rd_addr];
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule

@@ rtl/core/pip_edge.sv @@
// ----------------------------------------------------------------------------
// pip_edge
// Edge crossing unit: one shared multiplier gives both cross products of an
// edge, one in each phase; the compare follows in the cycle after the second.
// ----------------------------------------------------------------------------
module pip_edge
  import pip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  edge_ctl_t                 ctl,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  output logic                      flip_v,
  output logic                      flip
);

  logic signed [DIFF_W-1:0] dpx;
  logic signed [DIFF_W-1:0] dby;
  logic signed [DIFF_W-1:0] dbx;
  logic signed [DIFF_W-1:0] dpy;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     straddle;

  logic signed [PROD_W-1:0] lhs_r;
  logic signed [PROD_W-1:0] rhs_r;
  logic                     strad_r;
  logic                     dpos_r;
  logic                     cmp_v_r;

  assign dpx = $signed({px[COORD_W-1], px}) - $signed({ax[COORD_W-1], ax});
  assign dby = $signed({by[COORD_W-1], by}) - $signed({ay[COORD_W-1], ay});
  assign dbx = $signed({bx[COORD_W-1], bx}) - $signed({ax[COORD_W-1], ax});
  assign dpy = $signed({py[COORD_W-1], py}) - $signed({ay[COORD_W-1], ay});

  assign straddle = (ay > py) != (by > py);

  // shared multiplier
  assign mul_a = ctl.phase ? dbx : dpx;
  assign mul_b = ctl.phase ? dpy : dby;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctl.en && !ctl.phase) begin
      lhs_r <= prod;
    end
    if (ctl.en && ctl.phase) begin
      rhs_r   <= prod;
      strad_r <= straddle;
      dpos_r  <= by > ay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= ctl.en && ctl.phase;
    end
  end

  assign flip_v = cmp_v_r;
  assign flip   = cmp_v_r && strad_r && (dpos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r));

endmodule

@@ rtl/core/point_in_polygon_test_core.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Even-odd point-in-polygon test over a stored closed polygon.
// ----------------------------------------------------------------------------
// A load request (in_kind 0) writes one vertex at the edge it is accepted and
// never raises busy; an index at or beyond the vertex count is dropped. A test
// request (in_kind 1) walks every polygon edge through one shared multiplier,
// two products per edge, while busy stays high through the prime, edge and
// drain states. out_valid pulses for one cycle as busy falls, and a new request
// may be accepted while it is high. The receiver cannot stall: the result is
// there for exactly that one cycle.
module point_in_polygon_test_core
  import pip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic [VIDX_W-1:0]         in_vertex_index,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  output logic                      out_inside_res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_EDGE,
    ST_DRAIN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      phase_r, phase_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt;
  logic signed [COORD_W-1:0] py_r, py_nxt;
  logic signed [COORD_W-1:0] bx_r, bx_nxt;
  logic signed [COORD_W-1:0] by_r, by_nxt;
  logic                      parity_r, parity_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_inside_r, out_inside_nxt;

  logic                      accept;
  logic                      wr_en;
  logic [IDX_W-1:0]          rd_addr;
  logic signed [COORD_W-1:0] rd_x;
  logic signed [COORD_W-1:0] rd_y;
  edge_ctl_t                 ctl;
  logic                      flip_v;
  logic                      flip;

  assign busy   = state_r != ST_IDLE;
  assign accept = start && !busy;
  assign wr_en  = accept && (in_kind == KIND_LOAD) && (int'(in_vertex_index) < NUM_VERTICES);

  pip_vstore u_vstore (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_vertex_index)),
    .wr_x    (in_coord_x),
    .wr_y    (in_coord_y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pip_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .px     (px_r),
    .py     (py_r),
    .ax     (rd_x),
    .ay     (rd_y),
    .bx     (bx_r),
    .by     (by_r),
    .flip_v (flip_v),
    .flip   (flip)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    phase_nxt      = phase_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    bx_nxt         = bx_r;
    by_nxt         = by_r;
    parity_nxt     = parity_r ^ (flip_v && flip);
    out_valid_nxt  = 1'b0;
    out_inside_nxt = out_inside_r;
    rd_addr        = idx_r;
    ctl.en         = 1'b0;
    ctl.phase      = phase_r;
    case (state_r)
      ST_IDLE: begin
        rd_addr = LAST_IDX;
        if (accept && (in_kind == KIND_TEST)) begin
          state_nxt  = ST_PRIME;
          px_nxt     = in_coord_x;
          py_nxt     = in_coord_y;
          parity_nxt = 1'b0;
        end
      end
      ST_PRIME: begin
        // closing vertex becomes the trailing end of the first edge
        bx_nxt    = rd_x;
        by_nxt    = rd_y;
        rd_addr   = '0;
        idx_nxt   = '0;
        phase_nxt = 1'b0;
        state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        ctl.en = 1'b1;
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          bx_nxt    = rd_x;
          by_nxt    = rd_y;
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_DRAIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        state_nxt      = ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_inside_nxt = parity_r ^ (flip_v && flip);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      phase_r     <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    bx_r         <= bx_nxt;
    by_r         <= by_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

`ifndef NO_ASSERTIONS
  a_test_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_TEST)) |=> busy)
    else $error("test request did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_LOAD)) |=> !busy)
    else $error("load request raised busy");

  a_drain_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (out_valid && !busy))
    else $error("result strobe missing after last edge");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid))
    else $error("result strobe lasted more than one cycle");

  a_last_compare_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> flip_v)
    else $error("last edge compare not aligned with drain");
`endif

endmodule

@@ dv/point_in_polygon_test_core_test.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_test
// Drives vertex loads and point tests into the polygon core. A directed table
// covers the never-loaded polygon, out-of-range loads and a full-scale square
// with horizontal edges and points on edges. The table is followed by random
// polygons (tiny grids, medium, full range and stars), each with a burst of
// test points, mixed with noise requests. Results are checked against a known
// value or an even-odd crossing predictor holding its own vertex store copy.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  typedef struct packed {
    logic                      kind;
    logic [VIDX_W-1:0]         idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      known;
    logic                      res;
  } pip_req_t;

  localparam int ITEM_TARGET = 1550;
  localparam int STAR_COS [NUM_VERTICES] = '{1000, 809, 309, -309, -809,
                                             -1000, -809, -309, 309, 809};
  localparam int STAR_SIN [NUM_VERTICES] = '{0, 588, 951, 951, 588,
                                             0, -588, -951, -951, -588};

  localparam int DIR_ROWS = 24;
  localparam pip_req_t DIR_TABLE [DIR_ROWS] = '{
    '{KIND_TEST, 4'h0, 16'sh0000, 16'sh0000, 1'b1, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh8000, 16'sh7fff, 1'b1, 1'b0},
    '{KIND_TEST, 4'hf, 16'sh7fff, 16'sh8000, 1'b1, 1'b0},
    '{KIND_LOAD, 4'hf, 16'sh0064, 16'sh0064, 1'b0, 1'b0},
    '{KIND_LOAD, 4'ha, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh0000, 16'sh0000, 1'b1, 1'b0},
    '{KIND_LOAD, 4'h0, 16'sh8000, 16'sh8000, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h1, 16'sh0000, 16'sh8000, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h2, 16'sh7fff, 16'sh8000, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h3, 16'sh7fff, 16'sh0000, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h4, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h5, 16'sh0000, 16'sh7fff, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h6, 16'sh8000, 16'sh7fff, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h7, 16'sh8000, 16'sh4000, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h8, 16'sh8000, 16'sh0000, 1'b0, 1'b0},
    '{KIND_LOAD, 4'h9, 16'sh8000, 16'shc000, 1'b0, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh0000, 16'sh0000, 1'b0, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh8000, 16'sh0000, 1'b0, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh7fff, 16'sh0000, 1'b0, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh8000, 16'sh8000, 1'b0, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh0000, 16'sh7ffe, 1'b0, 1'b0},
    '{KIND_TEST, 4'h0, 16'sh0000, 16'sh8001, 1'b0, 1'b0},
    '{KIND_TEST, 4'ha, 16'shffff, 16'shffff, 1'b0, 1'b0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_kind;
  logic [VIDX_W-1:0]         in_vertex_index;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic                      out_valid;
  logic                      out_inside_res;
  logic                      known_on;
  logic                      known_res;

  logic signed [COORD_W-1:0] poly_x [NUM_VERTICES];
  logic signed [COORD_W-1:0] poly_y [NUM_VERTICES];
  logic                      inside_q [$];
  int                        err_cnt = 0;
  int                        item_cnt = 0;

  point_in_polygon_test_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_inside_res  (out_inside_res)
  );

  always #10 clk = ~clk;

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic point_inside(input logic signed [COORD_W-1:0] px,
                                        input logic signed [COORD_W-1:0] py);
    logic                      parity;
    int                        j;
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic signed [DIFF_W-1:0]  dy, dpx, dbx, dpy;
    logic signed [PROD_W-1:0]  lhs, rhs;
    parity = 1'b0;
    j = NUM_VERTICES - 1;
    for (int i = 0; i < NUM_VERTICES; i++) begin
      ax = poly_x[i];
      ay = poly_y[i];
      bx = poly_x[j];
      by = poly_y[j];
      if ((ay > py) != (by > py)) begin
        dy  = DIFF_W'(by) - DIFF_W'(ay);
        dpx = DIFF_W'(px) - DIFF_W'(ax);
        dbx = DIFF_W'(bx) - DIFF_W'(ax);
        dpy = DIFF_W'(py) - DIFF_W'(ay);
        lhs = dpx * dy;
        rhs = dbx * dpy;
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
          parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // results are checked before the request taken at the same edge is predicted
  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
        poly_x[i] = '0;
        poly_y[i] = '0;
      end
      inside_q.delete();
    end else begin
      if (out_valid) begin
        if (inside_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, inside_res=%0b",
                                    out_inside_res));
        end else begin
          want = inside_q.pop_front();
          if (out_inside_res !== want)
            report_mismatch($sformatf("inside_res=%0b, want %0b", out_inside_res, want));
        end
      end
      if (start && !busy) begin
        if (in_kind == KIND_TEST) begin
          inside_q.push_back(known_on ? known_res : point_inside(in_coord_x, in_coord_y));
        end else if (in_vertex_index < NUM_VERTICES) begin
          poly_x[in_vertex_index] = in_coord_x;
          poly_y[in_vertex_index] = in_coord_y;
        end
      end
    end
  end

  task automatic issue(input pip_req_t r);
    @(negedge clk);
    while (!(item_cnt >= 700 && item_cnt < 1000) && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_kind         <= r.kind;
    in_vertex_index <= r.idx;
    in_coord_x      <= r.x;
    in_coord_y      <= r.y;
    known_on        <= r.known;
    known_res       <= r.res;
    do @(posedge clk); while (busy !== 1'b0);
    if (r.kind == KIND_TEST || r.idx < NUM_VERTICES)
      item_cnt++;
  endtask

  initial begin : stimulus
    pip_req_t                  r;
    logic signed [COORD_W-1:0] vx [NUM_VERTICES];
    logic signed [COORD_W-1:0] vy [NUM_VERTICES];
    int                        mode, off, k, n_pts, sel, rad, cx, cy;
    int                        lox, hix, loy, hiy;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_LOAD;
    in_vertex_index = '0;
    in_coord_x      = '0;
    in_coord_y      = '0;
    known_on        = 1'b0;
    known_res       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      issue(DIR_TABLE[i]);

    while (item_cnt < ITEM_TARGET) begin
      r = '0;
      if ($urandom_range(9) < 7) begin
        // polygon with random content, then a burst of test points
        mode = int'($urandom_range(3));
        cx   = int'($urandom_range(16000)) - 8000;
        cy   = int'($urandom_range(16000)) - 8000;
        for (int i = 0; i < NUM_VERTICES; i++) begin
          case (mode)
            0: begin
              vx[i] = COORD_W'(int'($urandom_range(16)) - 8);
              vy[i] = COORD_W'(int'($urandom_range(16)) - 8);
            end
            1: begin
              vx[i] = COORD_W'(int'($urandom_range(4000)) - 2000);
              vy[i] = COORD_W'(int'($urandom_range(4000)) - 2000);
            end
            2: begin
              vx[i] = COORD_W'($urandom());
              vy[i] = COORD_W'($urandom());
            end
            default: begin
              rad   = int'($urandom_range(20000, 500));
              vx[i] = COORD_W'(cx + STAR_COS[i] * rad / 1000);
              vy[i] = COORD_W'(cy + STAR_SIN[i] * rad / 1000);
            end
          endcase
        end
        off = int'($urandom_range(NUM_VERTICES - 1));
        for (int i = 0; i < NUM_VERTICES; i++) begin
          if ($urandom_range(7) == 0) begin
            r.kind = KIND_LOAD;
            r.idx  = VIDX_W'($urandom_range(15, NUM_VERTICES));
            r.x    = COORD_W'($urandom());
            r.y    = COORD_W'($urandom());
            issue(r);
          end
          k      = (i + off) % NUM_VERTICES;
          r.kind = KIND_LOAD;
          r.idx  = VIDX_W'(k);
          r.x    = vx[k];
          r.y    = vy[k];
          issue(r);
        end
        lox = int'(vx[0]);
        hix = int'(vx[0]);
        loy = int'(vy[0]);
        hiy = int'(vy[0]);
        for (int i = 1; i < NUM_VERTICES; i++) begin
          if (int'(vx[i]) < lox) lox = int'(vx[i]);
          if (int'(vx[i]) > hix) hix = int'(vx[i]);
          if (int'(vy[i]) < loy) loy = int'(vy[i]);
          if (int'(vy[i]) > hiy) hiy = int'(vy[i]);
        end
        n_pts = int'($urandom_range(12, 3));
        for (int p = 0; p < n_pts; p++) begin
          sel    = int'($urandom_range(4));
          k      = int'($urandom_range(NUM_VERTICES - 1));
          r.kind = KIND_TEST;
          r.idx  = VIDX_W'($urandom_range(15));
          r.x    = COORD_W'(lox + int'($urandom_range(hix - lox)));
          r.y    = COORD_W'(loy + int'($urandom_range(hiy - loy)));
          case (sel)
            1: begin
              r.x = vx[k];
              r.y = vy[k];
            end
            2: r.y = vy[k];
            3: begin
              r.x = COORD_W'($urandom());
              r.y = COORD_W'($urandom());
            end
            4: r.y = COORD_W'(int'(vy[k]) + int'($urandom_range(2)) - 1);
            default: ;
          endcase
          issue(r);
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          r.kind = 1'($urandom_range(1));
          r.idx  = VIDX_W'($urandom_range(15));
          r.x    = COORD_W'($urandom());
          r.y    = COORD_W'($urandom());
          issue(r);
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (inside_q.size() != 0) @(posedge clk);
    repeat (2 * NUM_VERTICES + 6) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pip_pkg.sv
rtl/core/pip_vstore.sv
rtl/core/pip_edge.sv
rtl/core/point_in_polygon_test_core.sv
dv/point_in_polygon_test_core_test.sv
